/* hw/rtl/phec_pkg.sv */
`default_nettype none
package phec_pkg;

  // Default number of CORDIC cells and the most the angle table supports
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_MAX        = 24;

  // Field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned HDG_W  = 17;
  localparam int unsigned YAW_W  = 16;
  localparam int unsigned ERR_W  = 17;
  localparam int unsigned CMD_W  = 16;
  localparam int unsigned GAIN_W = 11;
  localparam int unsigned DB_W   = 15;
  localparam int unsigned CFG_W  = 15;

  // CORDIC datapath: magnitudes carry 16 fraction bits, angle in 2^-20 degree
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CW     = 44;
  localparam int unsigned AW     = 29;
  localparam int unsigned ANG_SHIFT = 13;

  localparam logic [AW-1:0] DEG90_FINE = 29'd94371840;
  localparam logic [14:0]   DEG90      = 15'd11520;
  localparam logic [16:0]   DEG180     = 17'd23040;
  localparam logic [16:0]   DEG360     = 17'd46080;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 11'd256;
  localparam logic [DB_W-1:0]   DB_RST   = 15'd384;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HEADING_GAIN   = 1'b0,
    REG_DEADBAND_WIDTH = 1'b1
  } cfg_reg_e;

  // Rotating vector and angle accumulator handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cordic_t;

  // Side data that rides along the CORDIC chain
  typedef struct packed {
    logic                    dx_neg;
    logic                    dz_neg;
    logic                    az_zero;
    logic                    ax_zero;
    logic signed [HDG_W-1:0] heading;
    logic                    done;
  } side_t;

  // Elementary angles atan(2^-i) in 2^-20 degree
  function automatic logic signed [AW-1:0] atan_fine(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = 29'sd47185920;
      1:  v = 29'sd27855475;
      2:  v = 29'sd14718068;
      3:  v = 29'sd7471121;
      4:  v = 29'sd3750058;
      5:  v = 29'sd1876857;
      6:  v = 29'sd938658;
      7:  v = 29'sd469357;
      8:  v = 29'sd234682;
      9:  v = 29'sd117342;
      10: v = 29'sd58671;
      11: v = 29'sd29335;
      12: v = 29'sd14668;
      13: v = 29'sd7334;
      14: v = 29'sd3667;
      15: v = 29'sd1833;
      16: v = 29'sd917;
      17: v = 29'sd458;
      18: v = 29'sd229;
      19: v = 29'sd115;
      20: v = 29'sd57;
      21: v = 29'sd29;
      22: v = 29'sd14;
      23: v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/phec_prep.sv */
`default_nettype none
module phec_prep (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [phec_pkg::POS_W-1:0] goal_x_i,
  input  wire  signed [phec_pkg::POS_W-1:0] goal_z_i,
  input  wire  signed [phec_pkg::POS_W-1:0] own_x_i,
  input  wire  signed [phec_pkg::POS_W-1:0] own_z_i,
  input  wire  signed [phec_pkg::HDG_W-1:0] heading_i,
  input  wire                          done_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output phec_pkg::cordic_t            out_cordic_o,
  output phec_pkg::side_t              out_side_o
);
  import phec_pkg::*;

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [DIFF_W-1:0] dx_q, dz_q;
  logic signed [HDG_W-1:0]  hdg_q;
  logic                     done_q;
  logic [POS_W-1:0]         ax, az;
  logic signed [DIFF_W-1:0] ndx, ndz;
  cordic_t                  cordic_q;
  side_t                    side_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Form the offset to the target
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      dx_q   <= DIFF_W'(goal_x_i) - DIFF_W'(own_x_i);
      dz_q   <= DIFF_W'(goal_z_i) - DIFF_W'(own_z_i);
      hdg_q  <= heading_i;
      done_q <= done_i;
    end
  end

  // Fold into the first quadrant and load the vector
  assign ndx = -dx_q;
  assign ndz = -dz_q;
  assign ax  = dx_q[DIFF_W-1] ? ndx[POS_W-1:0] : dx_q[POS_W-1:0];
  assign az  = dz_q[DIFF_W-1] ? ndz[POS_W-1:0] : dz_q[POS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      cordic_q.x      <= $signed({{(CW-POS_W-FRAC_W){1'b0}}, ax, {FRAC_W{1'b0}}});
      cordic_q.y      <= $signed({{(CW-POS_W-FRAC_W){1'b0}}, az, {FRAC_W{1'b0}}});
      cordic_q.ang    <= '0;
      side_q.dx_neg   <= dx_q[DIFF_W-1];
      side_q.dz_neg   <= dz_q[DIFF_W-1];
      side_q.az_zero  <= (az == '0);
      side_q.ax_zero  <= (ax == '0);
      side_q.heading  <= hdg_q;
      side_q.done     <= done_q;
    end
  end

  assign out_valid_o  = v2_q;
  assign out_cordic_o = cordic_q;
  assign out_side_o   = side_q;

endmodule
`default_nettype wire

/* hw/rtl/phec_cell.sv */
`default_nettype none
module phec_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  phec_pkg::cordic_t  in_cordic_i,
  input  phec_pkg::side_t    in_side_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output phec_pkg::cordic_t  out_cordic_o,
  output phec_pkg::side_t    out_side_o
);
  import phec_pkg::*;

  localparam logic signed [AW-1:0] ATAN = atan_fine(STAGE);

  logic                 valid_q;
  logic                 en;
  logic signed [CW-1:0] xs, ys;
  cordic_t              cordic_d, cordic_q;
  side_t                side_q;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // One vectoring micro-rotation toward the x axis
  assign xs = in_cordic_i.x >>> STAGE;
  assign ys = in_cordic_i.y >>> STAGE;

  always_comb begin
    if (!in_cordic_i.y[CW-1]) begin
      cordic_d.x   = in_cordic_i.x + ys;
      cordic_d.y   = in_cordic_i.y - xs;
      cordic_d.ang = in_cordic_i.ang + ATAN;
    end else begin
      cordic_d.x   = in_cordic_i.x - ys;
      cordic_d.y   = in_cordic_i.y + xs;
      cordic_d.ang = in_cordic_i.ang - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      cordic_q <= cordic_d;
      side_q   <= in_side_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_cordic_o = cordic_q;
  assign out_side_o   = side_q;

endmodule
`default_nettype wire

/* hw/rtl/phec_post.sv */
`default_nettype none
module phec_post (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  phec_pkg::cordic_t          in_cordic_i,
  input  phec_pkg::side_t            in_side_i,
  input  wire  [phec_pkg::GAIN_W-1:0] gain_i,
  input  wire  [phec_pkg::DB_W-1:0]   deadband_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [phec_pkg::YAW_W-1:0] yaw_o,
  output logic signed [phec_pkg::ERR_W-1:0] err_o,
  output logic signed [phec_pkg::CMD_W-1:0] cmd_o
);
  import phec_pkg::*;

  localparam int unsigned NP = 9;
  localparam int unsigned PW = ERR_W + GAIN_W + 1;
  localparam int unsigned NW = 20;
  localparam int unsigned KW = 19;
  localparam int unsigned QW = NW + KW;
  localparam int unsigned DIV_SHIFT = 21;
  localparam logic [KW-1:0] RECIP5 = 19'd419431;
  localparam logic signed [17:0] P180 = 18'sd23040;
  localparam logic signed [17:0] N180 = -18'sd23040;
  localparam logic signed [17:0] P360 = 18'sd46080;
  localparam logic [PW-1:0] HALF = PW'(1280);
  localparam logic [QW-DIV_SHIFT-1:0] POS_LIM = 18'd32767;
  localparam logic [QW-DIV_SHIFT-1:0] NEG_LIM = 18'd32768;

  logic [NP-1:0] v_q;
  logic [NP:0]   rdy;

  // Backpressure ripples down from the output register
  always_comb begin
    rdy[NP] = out_ready_i;
    for (int k = NP - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NP; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: clamp and round the first-quadrant angle, or take 0 or 90 degrees on an axis
  logic [AW-2:0]   clamp;
  logic [AW-2:0]   rnd;
  logic [14:0]     a0_q;
  side_t           s0_q;

  always_comb begin
    if (in_cordic_i.ang[AW-1]) begin
      clamp = '0;
    end else if (in_cordic_i.ang[AW-2:0] > DEG90_FINE[AW-2:0]) begin
      clamp = DEG90_FINE[AW-2:0];
    end else begin
      clamp = in_cordic_i.ang[AW-2:0];
    end
    rnd = clamp + (AW-1)'(1 << (ANG_SHIFT - 1));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      if (in_side_i.az_zero) begin
        a0_q <= '0;
      end else if (in_side_i.ax_zero) begin
        a0_q <= DEG90;
      end else begin
        a0_q <= rnd[ANG_SHIFT +: 15];
      end
      s0_q <= in_side_i;
    end
  end

  // Stage 1: map to the full circle, fold 360 to 0
  logic [16:0] yaw1_q;
  side_t       s1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      if (!s0_q.dz_neg) begin
        yaw1_q <= s0_q.dx_neg ? DEG180 - 17'(a0_q) : 17'(a0_q);
      end else if (!s0_q.dx_neg) begin
        yaw1_q <= (a0_q == '0) ? '0 : DEG360 - 17'(a0_q);
      end else begin
        yaw1_q <= DEG180 + 17'(a0_q);
      end
      s1_q <= s0_q;
    end
  end

  // Stage 2: raw heading error, forced to zero once navigation is done
  logic [16:0]        yaw2_q;
  logic signed [17:0] eraw_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      yaw2_q <= yaw1_q;
      eraw_q <= s1_q.done ? '0 : $signed({1'b0, yaw1_q}) - 18'(s1_q.heading);
    end
  end

  // Stage 3: single wrap into plus or minus 180
  logic [16:0]        yaw3_q;
  logic signed [17:0] ewrap_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      yaw3_q <= yaw2_q;
      if (eraw_q < N180) begin
        ewrap_q <= eraw_q + P360;
      end else if (eraw_q > P180) begin
        ewrap_q <= eraw_q - P360;
      end else begin
        ewrap_q <= eraw_q;
      end
    end
  end

  // Stage 4: deadband
  logic [ERR_W-1:0]        emag;
  logic [16:0]             yaw4_q;
  logic signed [ERR_W-1:0] err4_q;

  assign emag = ewrap_q[17] ? ERR_W'(-ewrap_q) : ewrap_q[ERR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      yaw4_q <= yaw3_q;
      err4_q <= (emag < ERR_W'(deadband_i)) ? '0 : ewrap_q[ERR_W-1:0];
    end
  end

  // Stage 5: scale by gain
  logic [16:0]             yaw5_q;
  logic signed [ERR_W-1:0] err5_q;
  logic signed [PW-1:0]    prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && v_q[4]) begin
      yaw5_q <= yaw4_q;
      err5_q <= err4_q;
      prod_q <= $signed(PW'(err4_q)) * $signed({{(PW-GAIN_W){1'b0}}, gain_i});
    end
  end

  // Stage 6: magnitude plus half, divide by 512
  logic [PW-1:0]           pmag;
  logic [PW-1:0]           psum;
  logic [16:0]             yaw6_q;
  logic signed [ERR_W-1:0] err6_q;
  logic [NW-1:0]           n6_q;
  logic                    neg6_q;

  assign pmag = prod_q[PW-1] ? PW'(-prod_q) : prod_q;
  assign psum = pmag + HALF;

  always_ff @(posedge clk_i) begin
    if (rdy[6] && v_q[5]) begin
      yaw6_q <= yaw5_q;
      err6_q <= err5_q;
      n6_q   <= psum[9 +: NW];
      neg6_q <= prod_q[PW-1];
    end
  end

  // Stage 7: divide by 5 through the reciprocal
  logic [16:0]             yaw7_q;
  logic signed [ERR_W-1:0] err7_q;
  logic [QW-1:0]           q7_q;
  logic                    neg7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7] && v_q[6]) begin
      yaw7_q <= yaw6_q;
      err7_q <= err6_q;
      q7_q   <= QW'(n6_q) * QW'(RECIP5);
      neg7_q <= neg6_q;
    end
  end

  // Stage 8: sign and saturate into the output register
  logic [QW-DIV_SHIFT-1:0] qmag;
  logic [YAW_W-1:0]        yaw8_q;
  logic signed [ERR_W-1:0] err8_q;
  logic signed [CMD_W-1:0] cmd8_q;

  assign qmag = q7_q[QW-1:DIV_SHIFT];

  always_ff @(posedge clk_i) begin
    if (rdy[8] && v_q[7]) begin
      yaw8_q <= yaw7_q[YAW_W-1:0];
      err8_q <= err7_q;
      if (!neg7_q) begin
        cmd8_q <= (qmag > POS_LIM) ? POS_LIM[CMD_W-1:0] : qmag[CMD_W-1:0];
      end else begin
        cmd8_q <= (qmag > NEG_LIM) ? NEG_LIM[CMD_W-1:0] : CMD_W'(-qmag);
      end
    end
  end

  assign out_valid_o = v_q[NP-1];
  assign yaw_o       = yaw8_q;
  assign err_o       = err8_q;
  assign cmd_o       = cmd8_q;

endmodule
`default_nettype wire

/* hw/rtl/pursuit_heading_error_controller.sv */
// Pure-pursuit heading controller.
// Slave stream: one request per beat carries target and own position, the
// current heading (tdata) and the navigation-done flag (tuser). Master stream:
// one result per request with bearing, wrapped heading error and drive command.
// Configuration: write heading_gain (index 0) or deadband_width (index 1) with
// cfg_we_i high for one cycle, only while no request is in flight.
// Throughput: one request per cycle while m_axis_tready_i is high. The bearing
// comes from a row of CORDIC_STAGES rotation cells (16 by default); a request
// passes 2 prep stages, the cells and 9 finishing stages before it reaches the
// output register.
// Stall: when the receiver holds m_axis_tready_i low, the result stays in the
// output register and the stages behind it keep filling empty slots; the
// slave side is only held once every stage is occupied.
// Reset: all stages are emptied, gain returns to 1.0 and deadband to 3 degrees.
`default_nettype none
module pursuit_heading_error_controller #(
  parameter int unsigned CORDIC_STAGES = phec_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // goal_x[23:0], goal_z[47:24], own_x[71:48], own_z[95:72],
  // heading[112:96], zero pad[119:113]
  input  wire  [119:0] s_axis_tdata_i,
  input  wire          s_axis_tuser_i,  // navigation_done
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // desired_yaw[15:0], heading_error[32:16], drive_command[48:33], zero pad[55:49]
  output logic [55:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  input  wire          cfg_we_i,
  input  wire  [0:0]   cfg_idx_i,
  input  wire  [phec_pkg::CFG_W-1:0] cfg_wdata_i
);
  import phec_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic [DB_W-1:0]   db_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      db_q   <= DB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADING_GAIN:   gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_DEADBAND_WIDTH: db_q   <= cfg_wdata_i[DB_W-1:0];
      endcase
    end
  end

  logic    v   [0:CORDIC_STAGES];
  logic    r   [0:CORDIC_STAGES];
  cordic_t c   [0:CORDIC_STAGES];
  side_t   s   [0:CORDIC_STAGES];

  phec_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .goal_x_i     ($signed(s_axis_tdata_i[23:0])),
    .goal_z_i     ($signed(s_axis_tdata_i[47:24])),
    .own_x_i      ($signed(s_axis_tdata_i[71:48])),
    .own_z_i      ($signed(s_axis_tdata_i[95:72])),
    .heading_i    ($signed(s_axis_tdata_i[112:96])),
    .done_i       (s_axis_tuser_i),
    .out_valid_o  (v[0]),
    .out_ready_i  (r[0]),
    .out_cordic_o (c[0]),
    .out_side_o   (s[0])
  );

  // Row of rotation cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    phec_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .in_valid_i   (v[g]),
      .in_ready_o   (r[g]),
      .in_cordic_i  (c[g]),
      .in_side_i    (s[g]),
      .out_valid_o  (v[g+1]),
      .out_ready_i  (r[g+1]),
      .out_cordic_o (c[g+1]),
      .out_side_o   (s[g+1])
    );
  end

  logic [YAW_W-1:0]        yaw;
  logic signed [ERR_W-1:0] err;
  logic signed [CMD_W-1:0] cmd;

  phec_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v[CORDIC_STAGES]),
    .in_ready_o  (r[CORDIC_STAGES]),
    .in_cordic_i (c[CORDIC_STAGES]),
    .in_side_i   (s[CORDIC_STAGES]),
    .gain_i      (gain_q),
    .deadband_i  (db_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .yaw_o       (yaw),
    .err_o       (err),
    .cmd_o       (cmd)
  );

  assign m_axis_tdata_o = {7'b0, cmd, err, yaw};

endmodule
`default_nettype wire
